>>> design/sfc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the sector framer.
// No dependencies; every other design file imports this package.
package sfc_pkg;

    localparam int SECTOR_BYTES  = 512;
    localparam int PAYLOAD_BYTES = SECTOR_BYTES - 5;
    localparam int POS_W         = $clog2(SECTOR_BYTES);
    localparam int OFF_W         = (POS_W > 9) ? POS_W : 9;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [7:0]  HEADER_RESET = 8'd1;
    localparam logic [23:0] START_RESET  = 24'd1;

    localparam int CFG_IDX_W  = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_HEADER_BYTE = 1'b0;
    localparam cfg_idx_t REG_BASE_SECTOR = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [8:0]  byte_offset;
        logic [23:0] sector_number;
        logic        sector_done;
        logic        length_error;
    } result_t;

    // One byte of reflected CRC-32, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/sector_framer_crc32_top.sv
// Top level of the CRC-32 sector framer.
// Depends on sfc_pkg, sfc_in_stage, sfc_framer and sfc_out_stage.
//
// Payload words go in one per cycle and come out one per cycle when nothing stalls, each
// tagged with its offset and sector number. The single output register sends one byte per
// cycle unless out_stall holds it, so a sector's first payload word yields two bytes
// (header, then the byte) and its last yields five (the byte, then four CRC bytes, LSB
// first, the final one flagged sector_done); every other word yields one. A buffer_end on
// a word that is not a sector's last payload byte yields a single length_error word, drops
// the partial sector and reuses its number. Writing the base sector register restarts
// framing at that value plus one; write config only while idle.
module sector_framer_crc32_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  sfc_pkg::cfg_idx_t cfg_index,
    input  logic [23:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              buffer_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic [8:0]        byte_offset,
    output logic [23:0]       sector_number,
    output logic              sector_done,
    output logic              length_error
);
    import sfc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_done;
    logic    take;
    logic    emit;
    result_t result;
    result_t out_result;

    assign in_item = '{data_byte: data_byte, buffer_end: buffer_end};

    sfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_done  (item_done),
        .item_valid (item_valid),
        .item       (item)
    );

    sfc_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .emit       (emit),
        .result     (result),
        .item_done  (item_done)
    );

    sfc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .result     (result),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign out_byte      = out_result.out_byte;
    assign byte_offset   = out_result.byte_offset;
    assign sector_number = out_result.sector_number;
    assign sector_done   = out_result.sector_done;
    assign length_error  = out_result.length_error;

endmodule

>>> design/sfc_in_stage.sv
// Input register of the sector framer: holds one word until the framer is done with it.
// Depends on sfc_pkg.
module sfc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sfc_pkg::item_t in_item,
    input  logic           item_done,
    output logic           item_valid,
    output sfc_pkg::item_t item
);
    import sfc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Take a new word in the same cycle the held one retires.
    assign in_stall = valid_reg && !item_done;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_done)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/sfc_framer.sv
// Sector framing sequencer: header, payload and CRC bytes, sector state and config registers.
// Depends on sfc_pkg (types, constants, crc_byte).
module sfc_framer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  sfc_pkg::cfg_idx_t cfg_index,
    input  logic [23:0]       cfg_wdata,
    input  logic              item_valid,
    input  sfc_pkg::item_t    item,
    input  logic              take,
    output logic              emit,
    output sfc_pkg::result_t  result,
    output logic              item_done
);
    import sfc_pkg::*;

    typedef enum logic [2:0] {
        S_ENTRY = 3'b001,
        S_BODY  = 3'b010,
        S_TAIL  = 3'b100
    } phase_t;

    phase_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [23:0]      cur_reg, cur_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [7:0]       hdr_reg, hdr_next;

    logic             fire;
    logic             last;
    logic             do_body;
    logic [31:0]      crc_data;
    logic [31:0]      crc_fin_sh;
    logic [OFF_W-1:0] offset_full;

    assign fire       = item_valid && take;
    assign last       = pos_reg >= POS_W'(PAYLOAD_BYTES - 1);
    assign crc_data   = crc_byte(crc_reg, item.data_byte);
    assign crc_fin_sh = (crc_reg ^ CRC_ALL_ONES) >> {cnt_reg, 3'b000};

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        hdr_next    = hdr_reg;
        emit        = 1'b0;
        item_done   = 1'b0;
        do_body     = 1'b0;
        offset_full = '0;
        result      = '{out_byte: 8'd0, byte_offset: 9'd0, sector_number: cur_reg,
                        sector_done: 1'b0, length_error: 1'b0};

        unique case (state_reg)
            S_ENTRY:
            begin
                if (fire)
                begin
                    if (item.buffer_end && !last)
                    begin
                        // drop the partial sector, keep the sector number
                        emit                = 1'b1;
                        result.length_error = 1'b1;
                        pos_next            = '0;
                        crc_next            = CRC_ALL_ONES;
                        item_done           = 1'b1;
                    end
                    else if (pos_reg == '0)
                    begin
                        emit            = 1'b1;
                        result.out_byte = hdr_reg;
                        crc_next        = crc_byte(CRC_ALL_ONES, hdr_reg);
                        state_next      = S_BODY;
                    end
                    else
                    begin
                        do_body = 1'b1;
                    end
                end
            end
            S_BODY:
            begin
                do_body = fire;
            end
            S_TAIL:
            begin
                if (fire)
                begin
                    emit               = 1'b1;
                    offset_full        = OFF_W'(SECTOR_BYTES - 4) + OFF_W'(cnt_reg);
                    result.out_byte    = crc_fin_sh[7:0];
                    result.byte_offset = offset_full[8:0];
                    cnt_next           = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        result.sector_done = 1'b1;
                        cur_next           = cur_reg + 24'd1;
                        pos_next           = '0;
                        crc_next           = CRC_ALL_ONES;
                        state_next         = S_ENTRY;
                        item_done          = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_ENTRY;
            end
        endcase

        if (do_body)
        begin
            emit               = 1'b1;
            offset_full        = OFF_W'(pos_reg) + OFF_W'(1);
            result.out_byte    = item.data_byte;
            result.byte_offset = offset_full[8:0];
            crc_next           = crc_data;
            pos_next           = pos_reg + POS_W'(1);
            if (last)
            begin
                // hold the word while the four CRC bytes go out
                state_next = S_TAIL;
                cnt_next   = 2'd0;
            end
            else
            begin
                state_next = S_ENTRY;
                item_done  = 1'b1;
            end
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HEADER_BYTE:
                begin
                    hdr_next = cfg_wdata[7:0];
                end
                REG_BASE_SECTOR:
                begin
                    cur_next   = cfg_wdata + 24'd1;
                    pos_next   = '0;
                    crc_next   = CRC_ALL_ONES;
                    cnt_next   = 2'd0;
                    state_next = S_ENTRY;
                end
                default:
                begin
                    hdr_next = hdr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ENTRY;
            pos_reg   <= '0;
            crc_reg   <= CRC_ALL_ONES;
            cur_reg   <= START_RESET + 24'd1;
            cnt_reg   <= 2'd0;
            hdr_reg   <= HEADER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
        end
    end

    a_tail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL) |-> (pos_reg == POS_W'(PAYLOAD_BYTES)))
        else $error("CRC bytes sent with payload count short of a full sector");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_TAIL) |-> (pos_reg < POS_W'(PAYLOAD_BYTES)))
        else $error("payload position ran past the sector");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.sector_done) |=> (pos_reg == '0 && crc_reg == CRC_ALL_ONES))
        else $error("sector state not cleared after final CRC byte");

    a_err_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.length_error) |-> (item_done && result.byte_offset == 9'd0))
        else $error("length error result did not retire its word");

endmodule

>>> design/sfc_out_stage.sv
// Output register of the sector framer: holds one result word until it is taken.
// Depends on sfc_pkg.
module sfc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             emit,
    input  sfc_pkg::result_t result,
    output logic             take,
    output logic             out_valid,
    input  logic             out_stall,
    output sfc_pkg::result_t out_result
);
    import sfc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign take = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;

endmodule
